// ===== hdl/three_sum_search_defines.svh =====
// ----------------------------------------------------------------------------
// Three-sum search assertion macros
// Shared property forms for the checker of the search block.
// ----------------------------------------------------------------------------
`ifndef THREE_SUM_SEARCH_DEFINES_SVH
`define THREE_SUM_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while the reset term is low.
`define TSS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the reset term is low.
`define TSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-sum search package
// Types and fixed constants shared by the search block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int TARGET_W   = 34;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_VAL_W  = 32;
  localparam int OUT_DATA_W = 3 * OUT_VAL_W;
  localparam int OUT_USER_W = 3;
  localparam int MIN_VALUES = 3;

  localparam logic signed [TARGET_W-1:0] TARGET_RESET = 34'sd27;

  typedef enum logic [1:0] {
    STATUS_FOUND = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_FEW   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_RD_J,
    S_RD_K,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/tss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/three_sum_search.sv =====
// ----------------------------------------------------------------------------
// Three-sum search
// Stores a set of signed values and searches index triples i<j<k in
// lexicographic order for the first one whose sum equals the target.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                        Contents
//   in_       slave      tvalid tready tdata tlast      one value, last of set
//   out_      master     tvalid tready tdata tuser      search result
//   cfg_      write      wr_en wr_data                  target sum
//
// Values load at one item per cycle. The search then reads one stored value
// per cycle: one value per i, one per (i, j) pair and one per k above j, until
// a match or the last triple, before the result is written out.
// Input is held off from the last item until the result is in the output
// register; a stalled output holds its item and blocks only the next search.
// Reset is synchronous: it clears the set and output valid, sets target to 27.
//
`default_nettype none

module three_sum_search #(
  parameter int STORE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] value
  input  wire logic [tss_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] first_value, [63:32] second_value, [95:64] third_value
  output logic      [tss_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status, [2] dropped
  output logic      [tss_pkg::OUT_USER_W-1:0]    out_tuser,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tss_pkg::TARGET_W-1:0]      cfg_wr_data
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int VW    = VALUE_WIDTH;
  localparam int CMP_W = (VALUE_WIDTH + 2 > tss_pkg::TARGET_W) ?
                         VALUE_WIDTH + 2 : tss_pkg::TARGET_W;

  tss_pkg::state_t  state_r, state_nxt;
  tss_pkg::status_t status_r, status_nxt;
  tss_pkg::status_t out_status_r, out_status_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] kq_r, kq_nxt;

  logic signed [tss_pkg::TARGET_W-1:0] target_r, target_nxt;
  logic signed [VW-1:0] a_r, a_nxt;
  logic signed [VW-1:0] b_r, b_nxt;
  logic signed [VW-1:0] c_r, c_nxt;
  logic signed [VW:0]   pair_r, pair_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_drop_r, out_drop_nxt;
  logic [tss_pkg::OUT_VAL_W-1:0]   out_first_r, out_first_nxt;
  logic [tss_pkg::OUT_VAL_W-1:0]   out_second_r, out_second_nxt;
  logic [tss_pkg::OUT_VAL_W-1:0]   out_third_r, out_third_nxt;

  logic              in_acc;
  logic              wr_en;
  logic [VW-1:0]     wr_data;
  logic [AW-1:0]     rd_addr;
  logic [VW-1:0]     rd_data;
  logic signed [VW-1:0]    rd_val;
  logic signed [CMP_W-1:0] sum_w;
  logic              hit;
  logic              k_end;
  logic              j_more;
  logic              i_more;
  logic              out_free;
  logic [CW-1:0]     cnt_after;

  tss_ram #(
    .WIDTH (VW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == tss_pkg::S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (cnt_r < CW'(STORE_DEPTH));
  assign wr_data   = VW'(in_tdata);
  assign cnt_after = wr_en ? cnt_r + CW'(1) : cnt_r;

  assign rd_val = signed'(rd_data);
  assign sum_w  = CMP_W'(pair_r) + CMP_W'(rd_val);
  assign hit    = (sum_w == CMP_W'(target_r));
  assign k_end  = (kq_r == cnt_r - CW'(1));
  assign j_more = ({1'b0, j_r} + (CW+1)'(2)) < {1'b0, cnt_r};
  assign i_more = ({1'b0, i_r} + (CW+1)'(3)) < {1'b0, cnt_r};

  assign out_free   = !out_valid_r || out_tready;
  assign target_nxt = cfg_wr_en ? signed'(cfg_wr_data) : target_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tss_pkg::S_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = (cnt_after < CW'(tss_pkg::MIN_VALUES)) ?
                      tss_pkg::S_DONE : tss_pkg::S_RD_I;
        end
      end
      tss_pkg::S_RD_I: state_nxt = tss_pkg::S_RD_J;
      tss_pkg::S_RD_J: state_nxt = tss_pkg::S_RD_K;
      tss_pkg::S_RD_K: state_nxt = tss_pkg::S_SCAN;
      tss_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = tss_pkg::S_DONE;
        end else if (k_end) begin
          if (j_more) begin
            state_nxt = tss_pkg::S_RD_K;
          end else if (i_more) begin
            state_nxt = tss_pkg::S_RD_J;
          end else begin
            state_nxt = tss_pkg::S_DONE;
          end
        end
      end
      tss_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = tss_pkg::S_LOAD;
        end
      end
      default: state_nxt = tss_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    kq_nxt         = kq_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    pair_nxt       = pair_r;
    status_nxt     = status_r;
    rd_addr        = i_r[AW-1:0];
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_drop_nxt   = out_drop_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_third_nxt  = out_third_r;
    case (state_r)
      tss_pkg::S_LOAD: begin
        if (wr_en) begin
          cnt_nxt = cnt_r + CW'(1);
        end else if (in_acc) begin
          ovf_nxt = 1'b1;
        end
        if (in_acc && in_tlast) begin
          i_nxt      = CW'(0);
          j_nxt      = CW'(1);
          k_nxt      = CW'(2);
          status_nxt = (cnt_after < CW'(tss_pkg::MIN_VALUES)) ?
                       tss_pkg::STATUS_FEW : tss_pkg::STATUS_NONE;
        end
      end
      tss_pkg::S_RD_I: begin
        rd_addr = i_r[AW-1:0];
      end
      tss_pkg::S_RD_J: begin
        a_nxt   = rd_val;
        rd_addr = j_r[AW-1:0];
      end
      tss_pkg::S_RD_K: begin
        b_nxt    = rd_val;
        pair_nxt = (VW+1)'(a_r) + (VW+1)'(rd_val);
        rd_addr  = k_r[AW-1:0];
        k_nxt    = k_r + CW'(1);
        kq_nxt   = k_r;
      end
      tss_pkg::S_SCAN: begin
        rd_addr = k_r[AW-1:0];
        k_nxt   = k_r + CW'(1);
        kq_nxt  = k_r;
        if (hit) begin
          c_nxt      = rd_val;
          status_nxt = tss_pkg::STATUS_FOUND;
        end else if (k_end) begin
          if (j_more) begin
            j_nxt   = j_r + CW'(1);
            k_nxt   = j_r + CW'(2);
            rd_addr = AW'(j_r + CW'(1));
          end else if (i_more) begin
            i_nxt   = i_r + CW'(1);
            j_nxt   = i_r + CW'(2);
            k_nxt   = i_r + CW'(3);
            rd_addr = AW'(i_r + CW'(1));
          end
        end
      end
      tss_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_drop_nxt   = ovf_r;
          if (status_r == tss_pkg::STATUS_FOUND) begin
            out_first_nxt  = tss_pkg::OUT_VAL_W'(a_r);
            out_second_nxt = tss_pkg::OUT_VAL_W'(b_r);
            out_third_nxt  = tss_pkg::OUT_VAL_W'(c_r);
          end else begin
            out_first_nxt  = '0;
            out_second_nxt = '0;
            out_third_nxt  = '0;
          end
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: begin
        rd_addr = i_r[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tss_pkg::S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      target_r    <= tss_pkg::TARGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      target_r    <= target_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    kq_r         <= kq_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    c_r          <= c_nxt;
    pair_r       <= pair_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_drop_r   <= out_drop_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_third_r  <= out_third_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_third_r, out_second_r, out_first_r};
  assign out_tuser  = {out_drop_r, out_status_r};

endmodule

`default_nettype wire

// ===== hdl/tss_checker.sv =====
// ----------------------------------------------------------------------------
// Three-sum search checker
// Port-level properties of the search block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_sum_search_defines.svh"

module tss_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tss_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [tss_pkg::OUT_USER_W-1:0]  out_tuser
);

  `TSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "Stalled output item changed.")
  `TSS_ASSERT_NEXT(a_reset_idle, clk, 1'b1, !rst_n, !out_tvalid, "Output valid after reset.")
  `TSS_ASSERT_SAME(a_miss_zero, clk, rst_n, out_tvalid && (out_tuser[1:0] != tss_pkg::STATUS_FOUND), out_tdata == '0, "Values not zero without a found triple.")
  `TSS_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "Input taken right after the last item of a set.")

endmodule

bind three_sum_search tss_checker u_tss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== test/three_sum_search_test.sv =====
// ----------------------------------------------------------------------------
// Three-sum search testbench
// Loads sets of signed values through the input stream and checks every
// search result against a predictor that keeps its own copy of the store and
// the target. Covers short and degenerate sets, extreme values and targets,
// a full store with dropped values, a long output stall, and random sets with
// planted triples under several idling patterns.
// ----------------------------------------------------------------------------
module three_sum_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     STORE_DEPTH    = 1024;
  localparam int     VALUE_WIDTH    = 32;
  localparam int     WATCHDOG_LIMIT = 100000;
  localparam longint VAL_MIN        = -64'sd2147483648;
  localparam longint VAL_MAX        = 64'sd2147483647;
  localparam longint TARGET_MIN     = -64'sd8589934592;
  localparam longint TARGET_MAX     = 64'sd8589934591;

  typedef struct {
    tss_pkg::status_t status;
    logic [31:0]      first_val;
    logic [31:0]      second_val;
    logic [31:0]      third_val;
    logic             dropped;
  } search_result_t;

  logic                                clk         = 1'b0;
  logic                                rst_n       = 1'b0;
  logic                                in_tvalid   = 1'b0;
  logic                                in_tready;
  logic [tss_pkg::IN_DATA_W-1:0]       in_tdata    = '0;
  logic                                in_tlast    = 1'b0;
  logic                                out_tvalid;
  logic                                out_tready  = 1'b0;
  logic [tss_pkg::OUT_DATA_W-1:0]      out_tdata;
  logic [tss_pkg::OUT_USER_W-1:0]      out_tuser;
  logic                                cfg_wr_en   = 1'b0;
  logic [tss_pkg::TARGET_W-1:0]        cfg_wr_data = '0;

  logic signed [31:0]                  stored_vals [STORE_DEPTH];
  int                                  stored_count  = 0;
  logic                                overflow_flag = 1'b0;
  logic signed [tss_pkg::TARGET_W-1:0] target_copy = tss_pkg::TARGET_RESET;
  search_result_t                      expected_results[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int sets_sent      = 0;
  int target_writes  = 0;
  int found_count    = 0;
  int none_count     = 0;
  int few_count      = 0;
  int dropped_count  = 0;

  three_sum_search #(
    .STORE_DEPTH(STORE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic search_result_t search_store();
    search_result_t r;
    bit             hit;
    longint         pair;
    r.status     = tss_pkg::STATUS_NONE;
    r.first_val  = '0;
    r.second_val = '0;
    r.third_val  = '0;
    r.dropped    = overflow_flag;
    hit          = 1'b0;
    if (stored_count < tss_pkg::MIN_VALUES) begin
      r.status = tss_pkg::STATUS_FEW;
    end else begin
      for (int i = 0; i < stored_count && !hit; i++) begin
        for (int j = i + 1; j < stored_count && !hit; j++) begin
          pair = longint'(stored_vals[i]) + longint'(stored_vals[j]);
          for (int k = j + 1; k < stored_count && !hit; k++) begin
            if (pair + longint'(stored_vals[k]) == longint'(target_copy)) begin
              hit          = 1'b1;
              r.status     = tss_pkg::STATUS_FOUND;
              r.first_val  = stored_vals[i];
              r.second_val = stored_vals[j];
              r.third_val  = stored_vals[k];
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void store_value(input logic [31:0] v, input logic last);
    if (stored_count < STORE_DEPTH) begin
      stored_vals[stored_count] = v;
      stored_count++;
    end else begin
      overflow_flag = 1'b1;
    end
    if (last) begin
      expected_results = {expected_results, search_store()};
      stored_count  = 0;
      overflow_flag = 1'b0;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    search_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: tuser %h tdata %h", out_tuser, out_tdata);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(out_tuser[1:0]));
      compare_field("first_value", want.first_val, out_tdata[31:0]);
      compare_field("second_value", want.second_val, out_tdata[63:32]);
      compare_field("third_value", want.third_val, out_tdata[95:64]);
      compare_field("dropped", 32'(want.dropped), 32'(out_tuser[2]));
      case (want.status)
        tss_pkg::STATUS_FOUND: found_count++;
        tss_pkg::STATUS_NONE:  none_count++;
        default:               few_count++;
      endcase
      if (want.dropped) dropped_count++;
    end
  endfunction

  // Prediction and checking share one process so that a last item and a
  // result taken at the same edge are handled in a fixed order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) target_copy = cfg_wr_data;
      if (in_tvalid && in_tready) store_value(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
  end

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("three_sum_search_test: done, errors");
      $finish;
    end
  end

  function automatic longint rand_between(input longint lo, input longint hi);
    longint unsigned span;
    longint unsigned r;
    span = longint'(hi - lo) + 1;
    r    = {$urandom, $urandom};
    return lo + longint'(r % span);
  endfunction

  // Picks three in-range values whose sum is the target, if any exist.
  function automatic bit plant_triple(input longint t, output longint a,
                                      output longint b, output longint c);
    longint lo;
    longint hi;
    longint rest;
    lo = (t - 2 * VAL_MAX > VAL_MIN) ? t - 2 * VAL_MAX : VAL_MIN;
    hi = (t - 2 * VAL_MIN < VAL_MAX) ? t - 2 * VAL_MIN : VAL_MAX;
    if (lo > hi) return 1'b0;
    a    = rand_between(lo, hi);
    rest = t - a;
    lo   = (rest - VAL_MAX > VAL_MIN) ? rest - VAL_MAX : VAL_MIN;
    hi   = (rest - VAL_MIN < VAL_MAX) ? rest - VAL_MIN : VAL_MAX;
    b    = rand_between(lo, hi);
    c    = rest - b;
    return 1'b1;
  endfunction

  function automatic longint pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 40) return longint'($urandom_range(240)) - 120;
    if (r < 80) return rand_between(3 * VAL_MIN, 3 * VAL_MAX);
    return rand_between(TARGET_MIN, TARGET_MAX);
  endfunction

  task automatic send_item(input logic [31:0] v, input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set(input logic [31:0] vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
    sets_sent++;
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_target(input longint t);
    wait_until_idle();
    cfg_wr_data <= t[tss_pkg::TARGET_W-1:0];
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    target_writes++;
  endtask

  task automatic test_basic_sets();
    send_set('{32'd10, 32'd8, 32'd9});
    send_set('{32'd5});
    send_set('{32'd1, 32'd2});
    send_set('{32'd1, 32'd2, 32'd3});
    write_target(3 * VAL_MAX);
    send_set('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    write_target(3 * VAL_MIN);
    send_set('{32'h80000000, 32'h80000000, 32'h80000000});
    write_target(TARGET_MIN);
    send_set('{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000000});
    write_target(TARGET_MAX);
    send_set('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
  endtask

  // The only matching triple uses the top entry, so the scan reaches the
  // store's boundary; the two items past the top, the last one included,
  // are dropped.
  task automatic test_store_full();
    logic [31:0] vals[$];
    write_target(27);
    for (int i = 0; i < STORE_DEPTH + 2; i++) vals = {vals, 32'd1000};
    vals[0]               = 32'd10;
    vals[1]               = 32'd8;
    vals[STORE_DEPTH - 1] = 32'd9;
    vals[STORE_DEPTH]     = 32'd9;
    vals[STORE_DEPTH + 1] = 32'd9;
    send_set(vals);
  endtask

  task automatic test_output_backpressure();
    write_target(27);
    hold_request = 2000;
    @(posedge clk);
    for (int s = 0; s < 6; s++) send_set('{32'd1, 32'd2, 32'd24});
    wait_until_idle();
  endtask

  task automatic test_random_sets();
    int          phase_src  [4] = '{0, 70, 0, 16};
    int          phase_sink [4] = '{0, 0, 70, 16};
    logic [31:0] vals[$];
    int          n;
    int          kind;
    int          phase_items;
    int          phase_sets;
    int          p0;
    int          p1;
    int          p2;
    bit          small_vals;
    longint      a;
    longint      b;
    longint      c;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      phase_items    = 0;
      phase_sets     = 0;
      while (phase_items < 50) begin
        if (phase_sets % 8 == 0) write_target(pick_target());
        kind = $urandom_range(99);
        if (kind < 10) begin
          n = $urandom_range(2, 1);
        end else if (kind < 15) begin
          n = $urandom_range(40, 20);
        end else begin
          n = $urandom_range(12, 3);
        end
        small_vals = $urandom_range(1);
        vals.delete();
        for (int i = 0; i < n; i++) begin
          if (small_vals) vals = {vals, 32'(int'($urandom_range(80)) - 40)};
          else vals = {vals, 32'($urandom)};
        end
        if (n >= 3 && $urandom_range(99) < 60 && plant_triple(longint'(target_copy), a, b, c))
        begin
          p0       = $urandom_range(n - 3);
          p1       = $urandom_range(n - 2, p0 + 1);
          p2       = $urandom_range(n - 1, p1 + 1);
          vals[p0] = a[31:0];
          vals[p1] = b[31:0];
          vals[p2] = c[31:0];
        end
        send_set(vals);
        phase_items += n;
        phase_sets++;
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_sets();
    test_store_full();
    test_output_backpressure();
    test_random_sets();
    wait_until_idle();
    repeat (16) @(posedge clk);
    $display("Sent %0d items in %0d sets over %0d target settings and four idling patterns.",
             items_sent, sets_sent, target_writes);
    $display("Results: %0d found, %0d without a match, %0d too short, %0d with drops.",
             found_count, none_count, few_count, dropped_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("three_sum_search_test: done, clean");
    end else begin
      $display("three_sum_search_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== three_sum_search.f =====
+incdir+hdl
hdl/tss_pkg.sv
hdl/tss_ram.sv
hdl/three_sum_search.sv
hdl/tss_checker.sv
test/three_sum_search_test.sv
